// File: sv/bbr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbr_pkg
// Shared widths, types, register indexes and lane helpers for the bounding
// box rescaler pipeline.
// ----------------------------------------------------------------------------
package bbr_pkg;

   // Coordinate and size width, product width for the scaling multiply
   localparam int COORD_WIDTH = 12;
   localparam int PROD_WIDTH  = 2 * COORD_WIDTH;

   // Four coordinates per box, one lane each
   localparam int LANES      = 4;
   localparam int LANE_LEFT  = 0;
   localparam int LANE_TOP   = 1;
   localparam int LANE_RIGHT = 2;
   localparam int LANE_BOTTOM = 3;

   // Configuration register indexes
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SOURCE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SOURCE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TARGET_WIDTH  = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TARGET_HEIGHT = 2'd3;

   // Size register reset values
   localparam int RESET_SOURCE_WIDTH  = 256;
   localparam int RESET_SOURCE_HEIGHT = 192;
   localparam int RESET_TARGET_WIDTH  = 256;
   localparam int RESET_TARGET_HEIGHT = 192;

   typedef logic [COORD_WIDTH-1:0] coord_type;
   typedef logic [PROD_WIDTH-1:0]  prod_type;
   typedef coord_type [LANES-1:0]  coord_vec_type;
   typedef prod_type  [LANES-1:0]  prod_vec_type;

   // Frame sizes as seen by every pipeline stage
   typedef struct packed {
      coord_type src_w;
      coord_type src_h;
      coord_type dst_w;
      coord_type dst_h;
   } sizes_type;

   // Left and right lanes scale along x, top and bottom along y
   function automatic logic lane_is_x(input int lane);
      return (lane == LANE_LEFT) || (lane == LANE_RIGHT);
   endfunction

   function automatic coord_type lane_src(input sizes_type s, input int lane);
      return lane_is_x(lane) ? s.src_w : s.src_h;
   endfunction

   function automatic coord_type lane_dst(input sizes_type s, input int lane);
      return lane_is_x(lane) ? s.dst_w : s.dst_h;
   endfunction

endpackage

// File: sv/bbr_mul_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbr_mul_stage
// Clamps each coordinate to the source size minus one and multiplies it by
// the preview size. One register stage.
// ----------------------------------------------------------------------------
module bbr_mul_stage
   import bbr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  coord_vec_type in_coord,
   input  sizes_type     sizes,
   output logic          out_valid,
   output prod_vec_type  out_prod
);

   logic         valid_ff;
   prod_vec_type prod_ff;
   prod_vec_type prod_in;
   coord_vec_type clamped;

   // Clamp then scale up, all four lanes side by side
   always_comb begin
      for (int lane = 0; lane < LANES; lane++) begin
         clamped[lane] = (in_coord[lane] > (lane_src(sizes, lane) - 1'b1)) ?
                         (lane_src(sizes, lane) - 1'b1) : in_coord[lane];
         prod_in[lane] = prod_type'(clamped[lane]) *
                         prod_type'(lane_dst(sizes, lane));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign out_valid = valid_ff;
   assign out_prod  = prod_ff;

endmodule

// File: sv/bbr_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbr_div_stage
// One restoring division step per lane: produces one quotient bit of
// product / source size. The word holds the partial remainder in its upper
// half and the unused dividend bits, then the quotient bits, in its lower.
// ----------------------------------------------------------------------------
module bbr_div_stage
   import bbr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  prod_vec_type in_word,
   input  sizes_type    sizes,
   output logic         out_valid,
   output prod_vec_type out_word
);

   logic         valid_ff;
   prod_vec_type word_ff;
   prod_vec_type word_in;

   // Shift in the next dividend bit, subtract the divisor where it fits
   function automatic prod_type div_step(input prod_type word, input coord_type d);
      logic [COORD_WIDTH:0]   trial;
      logic [COORD_WIDTH:0]   diff;
      logic                   fits;
      coord_type              rem;
      trial = {word[PROD_WIDTH-1:COORD_WIDTH], word[COORD_WIDTH-1]};
      diff  = trial - {1'b0, d};
      fits  = (trial >= {1'b0, d});
      rem   = fits ? diff[COORD_WIDTH-1:0] : trial[COORD_WIDTH-1:0];
      return {rem, word[COORD_WIDTH-2:0], fits};
   endfunction

   always_comb begin
      for (int lane = 0; lane < LANES; lane++) begin
         word_in[lane] = div_step(in_word[lane], lane_src(sizes, lane));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

// File: sv/bbr_fix_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbr_fix_stage
// Clamps each quotient to the preview size minus one, forces zero when any
// size is zero, and widens an empty or inverted axis to min plus one.
// ----------------------------------------------------------------------------
module bbr_fix_stage
   import bbr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  prod_vec_type  in_word,
   input  sizes_type     sizes,
   output logic          out_valid,
   output coord_vec_type out_coord
);

   logic          valid_ff;
   coord_vec_type coord_ff;
   coord_vec_type coord_in;
   coord_vec_type scaled;
   logic          sizes_ok;

   assign sizes_ok = (sizes.src_w != '0) && (sizes.src_h != '0) &&
                     (sizes.dst_w != '0) && (sizes.dst_h != '0);

   // Quotient sits in the low half of the division word
   always_comb begin
      for (int lane = 0; lane < LANES; lane++) begin
         if (!sizes_ok) begin
            scaled[lane] = '0;
         end else if (in_word[lane][COORD_WIDTH-1:0] > (lane_dst(sizes, lane) - 1'b1)) begin
            scaled[lane] = lane_dst(sizes, lane) - 1'b1;
         end else begin
            scaled[lane] = in_word[lane][COORD_WIDTH-1:0];
         end
      end
   end

   // Max corner at least one above min on each axis
   always_comb begin
      coord_in = scaled;
      if (scaled[LANE_RIGHT] <= scaled[LANE_LEFT]) begin
         coord_in[LANE_RIGHT] = scaled[LANE_LEFT] + 1'b1;
      end
      if (scaled[LANE_BOTTOM] <= scaled[LANE_TOP]) begin
         coord_in[LANE_BOTTOM] = scaled[LANE_TOP] + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      coord_ff <= coord_in;
   end

   assign out_valid = valid_ff;
   assign out_coord = coord_ff;

endmodule

// File: sv/bounding_box_rescaler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounding_box_rescaler
// Maps a source-frame bounding box into preview coordinates set by four
// size registers, one box per clock.
// ----------------------------------------------------------------------------
// A box is taken on every cycle with start high; busy never rises. Each
// result appears on the rsp_ ports for one cycle with rsp_valid high, in
// order. The path is one multiply stage, then one restoring division
// stage per quotient bit, then a clamp and fixup stage.
// The receiver cannot stall, so every result must be taken as it comes.
// Size registers must only be written while no box is in flight.
// ----------------------------------------------------------------------------
module bounding_box_rescaler
   import bbr_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // box input
   input  logic                       start,
   output logic                       busy,
   input  coord_type                  req_src_left,
   input  coord_type                  req_src_top,
   input  coord_type                  req_src_right,
   input  coord_type                  req_src_bottom,
   // result output
   output logic                       rsp_valid,
   output coord_type                  rsp_dst_left,
   output coord_type                  rsp_dst_top,
   output coord_type                  rsp_dst_right,
   output coord_type                  rsp_dst_bottom,
   // size registers
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  coord_type                  csr_data
);

   sizes_type     sizes_ff;
   sizes_type     sizes_in;
   coord_vec_type req_coord;
   coord_vec_type rsp_coord;
   logic          accept;
   logic          fix_valid;
   logic          div_valid [0:COORD_WIDTH];
   prod_vec_type  div_word  [0:COORD_WIDTH];

   // Pipeline never stalls
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start & ~busy;

   // Size register writes
   always_comb begin
      sizes_in = sizes_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SOURCE_WIDTH:  sizes_in.src_w = csr_data;
            CSR_SOURCE_HEIGHT: sizes_in.src_h = csr_data;
            CSR_TARGET_WIDTH:  sizes_in.dst_w = csr_data;
            CSR_TARGET_HEIGHT: sizes_in.dst_h = csr_data;
            default:           sizes_in = sizes_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sizes_ff.src_w <= coord_type'(RESET_SOURCE_WIDTH);
         sizes_ff.src_h <= coord_type'(RESET_SOURCE_HEIGHT);
         sizes_ff.dst_w <= coord_type'(RESET_TARGET_WIDTH);
         sizes_ff.dst_h <= coord_type'(RESET_TARGET_HEIGHT);
      end else begin
         sizes_ff <= sizes_in;
      end
   end

   // Gather the box into lanes
   always_comb begin
      req_coord[LANE_LEFT]   = req_src_left;
      req_coord[LANE_TOP]    = req_src_top;
      req_coord[LANE_RIGHT]  = req_src_right;
      req_coord[LANE_BOTTOM] = req_src_bottom;
   end

   // Clamp and multiply
   bbr_mul_stage u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_coord  (req_coord),
      .sizes     (sizes_ff),
      .out_valid (div_valid[0]),
      .out_prod  (div_word[0])
   );

   // Division chain, one quotient bit per stage
   for (genvar s = 0; s < COORD_WIDTH; s++) begin : g_div
      bbr_div_stage u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[s]),
         .in_word   (div_word[s]),
         .sizes     (sizes_ff),
         .out_valid (div_valid[s+1]),
         .out_word  (div_word[s+1])
      );
   end

   // Clamp to preview and fix empty axes
   bbr_fix_stage u_fix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid[COORD_WIDTH]),
      .in_word   (div_word[COORD_WIDTH]),
      .sizes     (sizes_ff),
      .out_valid (fix_valid),
      .out_coord (rsp_coord)
   );

   assign rsp_valid      = fix_valid;
   assign rsp_dst_left   = rsp_coord[LANE_LEFT];
   assign rsp_dst_top    = rsp_coord[LANE_TOP];
   assign rsp_dst_right  = rsp_coord[LANE_RIGHT];
   assign rsp_dst_bottom = rsp_coord[LANE_BOTTOM];

endmodule
